FILE: rtl/dbmt_pkg.sv
// block map translator package: field widths, codes, request/result structs
// and the command/status bundles between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package dbmt_pkg;

    localparam int LBA_W   = 48;
    localparam int BS_W    = 17;
    localparam int NB_W    = 13;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = 16;
    localparam int FS_W    = 33;
    localparam int IDX_W   = 12;
    localparam int CFG_A_W = 2;

    localparam logic [CNT_W-1:0] MAX_COUNT      = 16'd32768;
    localparam logic [BS_W-1:0]  MIN_BLOCK      = 17'd1024;
    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE = 17'd2048;

    // request function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // per-result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FREE   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    // overall status
    localparam logic [1:0] OV_ALLOC = 2'd0;
    localparam logic [1:0] OV_NONE  = 2'd1;
    localparam logic [1:0] OV_FAIL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_NUM_BLOCKS   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_FREE_MARKER  = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_FILE_SECTORS = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  map_index;
        logic [WORD_W-1:0] map_value;
        logic [LBA_W-1:0]  lba;
        logic [LBA_W-1:0]  lba_end;
        logic [CNT_W-1:0]  sector_count;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [FS_W-1:0]  file_sector;
        logic [CNT_W-1:0] chunk_sectors;
        logic [1:0]       overall_status;
        logic             last;
    } t_result;

    typedef enum logic [2:0] {
        EM_NONE  = 3'd0,
        EM_LOAD  = 3'd1,
        EM_FAIL  = 3'd2,
        EM_EMPTY = 3'd3,
        EM_CHUNK = 3'd4,
        EM_QUERY = 3'd5
    } t_emit;

    typedef struct packed {
        logic  latch;
        logic  div_start;
        logic  init;
        logic  step;
        logic  rd_issue;
        logic  set_any;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       div_done;
        logic       blk_oob;
        logic       chunk_last;
        logic       entry_used;
        logic       q_cont;
    } t_stat;

endpackage

FILE: rtl/dbmt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dbmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dbmt_div.sv
// restoring divider, one quotient bit per cycle: sector number by block size
// depends on dbmt_pkg
`timescale 1ns / 1ps

module dbmt_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dbmt_pkg::LBA_W-1:0] i_dividend,
    input  logic [dbmt_pkg::BS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [dbmt_pkg::LBA_W-1:0] o_quotient,
    output logic [dbmt_pkg::BS_W-1:0]  o_remainder
);
    import dbmt_pkg::*;

    localparam int CW = $clog2(LBA_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(LBA_W - 1);

    logic [LBA_W-1:0] r_q,    n_q;
    logic [BS_W-1:0]  r_rem,  n_rem;
    logic [BS_W-1:0]  r_div;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BS_W:0]    trial;
    logic             fits;

    always_comb begin
        trial = {r_rem, r_q[LBA_W-1]};
        fits  = trial >= {1'b0, r_div};
        n_q   = {r_q[LBA_W-2:0], fits};
        n_rem = fits ? BS_W'(trial - {1'b0, r_div}) : trial[BS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

FILE: rtl/dbmt_ctrl.sv
// controller: sequences loads, read splitting (scan pass then emit pass) and
// range queries; depends on dbmt_pkg
`timescale 1ns / 1ps

module dbmt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dbmt_pkg::t_stat i_stat,
    output dbmt_pkg::t_cmd  o_cmd,
    output logic            busy
);
    import dbmt_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DISP   = 11'b000_0000_0010,
        S_DIV    = 11'b000_0000_0100,
        S_CHECK  = 11'b000_0000_1000,
        S_SC_RD  = 11'b000_0001_0000,
        S_SC_CHK = 11'b000_0010_0000,
        S_EM_RD  = 11'b000_0100_0000,
        S_EM_OUT = 11'b000_1000_0000,
        S_Q_TEST = 11'b001_0000_0000,
        S_Q_CHK  = 11'b010_0000_0000,
        S_Q_EMIT = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '{emit: EM_NONE, default: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.func == FUNC_LOAD) begin
                    cmd.emit = EM_LOAD;
                    n_state  = S_IDLE;
                end else if (i_stat.func == FUNC_READ && i_stat.cnt_zero) begin
                    cmd.emit = EM_EMPTY;
                    n_state  = S_IDLE;
                end else if (i_stat.func == FUNC_READ || i_stat.func == FUNC_QUERY) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end else begin
                    cmd.emit = EM_FAIL;
                    n_state  = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.func == FUNC_READ && i_stat.blk_oob) begin
                    cmd.emit = EM_FAIL;
                    n_state  = S_IDLE;
                end else begin
                    cmd.init = 1'b1;
                    n_state  = (i_stat.func == FUNC_READ) ? S_SC_RD : S_Q_TEST;
                end
            end
            // scan pass: find whether any chunk of the read is allocated
            S_SC_RD: begin
                cmd.rd_issue = 1'b1;
                n_state      = S_SC_CHK;
            end
            S_SC_CHK: begin
                if (i_stat.entry_used || i_stat.chunk_last) begin
                    cmd.set_any = i_stat.entry_used;
                    cmd.init    = 1'b1;
                    n_state     = S_EM_RD;
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_SC_RD;
                end
            end
            // emit pass: same chunk walk, one result per chunk
            S_EM_RD: begin
                cmd.rd_issue = 1'b1;
                n_state      = S_EM_OUT;
            end
            S_EM_OUT: begin
                cmd.emit = EM_CHUNK;
                cmd.step = 1'b1;
                n_state  = i_stat.chunk_last ? S_IDLE : S_EM_RD;
            end
            S_Q_TEST: begin
                if (i_stat.q_cont) begin
                    cmd.rd_issue = 1'b1;
                    n_state      = S_Q_CHK;
                end else begin
                    n_state = S_Q_EMIT;
                end
            end
            S_Q_CHK: begin
                if (i_stat.entry_used) begin
                    cmd.set_any = 1'b1;
                    n_state     = S_Q_EMIT;
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_Q_TEST;
                end
            end
            S_Q_EMIT: begin
                cmd.emit = EM_QUERY;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

FILE: rtl/dbmt_dp.sv
// datapath: configuration registers, block map ram, two dividers, chunk walker
// and the result register; depends on dbmt_pkg, dbmt_ram, dbmt_div
`timescale 1ns / 1ps

module dbmt_dp #(
    parameter int MAP_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dbmt_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [dbmt_pkg::WORD_W-1:0]  i_cfg_wdata,
    input  dbmt_pkg::t_req               i_req,
    input  dbmt_pkg::t_cmd               i_cmd,
    output dbmt_pkg::t_stat              o_stat,
    output logic                         o_strobe,
    output dbmt_pkg::t_result            o_result
);
    import dbmt_pkg::*;

    localparam int AW  = $clog2(MAP_DEPTH);
    localparam int NBW = (AW + 1 > NB_W) ? AW + 1 : NB_W;
    localparam int IW  = (AW > IDX_W) ? AW : IDX_W;

    // configuration
    logic [BS_W-1:0]   r_block_size;
    logic [NB_W-1:0]   r_num_blocks;
    logic [WORD_W-1:0] r_free_marker;
    logic [WORD_W-1:0] r_file_sectors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= RST_BLOCK_SIZE;
            r_num_blocks   <= '0;
            r_free_marker  <= '0;
            r_file_sectors <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BLOCK_SIZE:   r_block_size   <= i_cfg_wdata[BS_W-1:0];
                REG_NUM_BLOCKS:   r_num_blocks   <= i_cfg_wdata[NB_W-1:0];
                REG_FREE_MARKER:  r_free_marker  <= i_cfg_wdata;
                REG_FILE_SECTORS: r_file_sectors <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [BS_W-1:0]  eff_bs;
    logic [NBW-1:0]   eff_nb;
    logic [LBA_W-1:0] nb_wide;

    assign eff_bs  = (r_block_size < MIN_BLOCK) ? MIN_BLOCK : r_block_size;
    assign eff_nb  = (NBW'(r_num_blocks) > NBW'(MAP_DEPTH)) ? NBW'(MAP_DEPTH)
                                                             : NBW'(r_num_blocks);
    assign nb_wide = LBA_W'(eff_nb);

    // request capture
    t_req             r_req;
    logic [CNT_W-1:0] cnt_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
    end

    assign cnt_sat = (r_req.sector_count > MAX_COUNT) ? MAX_COUNT : r_req.sector_count;

    // start and end block of the request
    logic             div_done, div_done_end;
    logic [LBA_W-1:0] q_start, q_end;
    logic [BS_W-1:0]  rem_start, rem_end;

    dbmt_div u_div_start (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_req.lba),
        .i_divisor   (eff_bs),
        .o_done      (div_done),
        .o_quotient  (q_start),
        .o_remainder (rem_start)
    );

    dbmt_div u_div_end (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_req.lba_end),
        .i_divisor   (eff_bs),
        .o_done      (div_done_end),
        .o_quotient  (q_end),
        .o_remainder (rem_end)
    );

    // chunk walker
    logic [LBA_W-1:0] r_blk,  n_blk;
    logic [BS_W-1:0]  r_off,  n_off;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_any,  n_any;
    logic [BS_W-1:0]  left;
    logic [CNT_W-1:0] take;
    logic [CNT_W-1:0] cnt_after;
    logic [LBA_W-1:0] blk_inc;

    always_comb begin
        left      = eff_bs - r_off;
        take      = (left <= BS_W'(r_cnt)) ? left[CNT_W-1:0] : r_cnt;
        cnt_after = r_cnt - take;
        blk_inc   = r_blk + 1'b1;

        n_blk = r_blk;
        n_off = r_off;
        n_cnt = r_cnt;
        n_any = r_any;
        if (i_cmd.init) begin
            n_blk = q_start;
            n_off = rem_start;
            n_cnt = cnt_sat;
        end else if (i_cmd.step) begin
            n_blk = blk_inc;
            n_off = '0;
            n_cnt = cnt_after;
        end
        if (i_cmd.latch) begin
            n_any = 1'b0;
        end else if (i_cmd.set_any) begin
            n_any = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any <= 1'b0;
        end else begin
            r_any <= n_any;
        end
        r_blk <= n_blk;
        r_off <= n_off;
        r_cnt <= n_cnt;
    end

    // block map
    logic [IW-1:0]     idx_w;
    logic              idx_ok;
    logic              map_we;
    logic [WORD_W-1:0] map_rdata;
    logic              entry_used;

    assign idx_w  = IW'(r_req.map_index);
    assign idx_ok = {1'b0, idx_w} < (IW + 1)'(MAP_DEPTH);
    assign map_we = (i_cmd.emit == EM_LOAD) && idx_ok;

    dbmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (idx_w[AW-1:0]),
        .i_wdata (r_req.map_value),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_blk[AW-1:0]),
        .o_rdata (map_rdata)
    );

    assign entry_used = (map_rdata != r_free_marker);

    // status to controller
    always_comb begin
        o_stat.func       = r_req.func;
        o_stat.cnt_zero   = (r_req.sector_count == '0);
        o_stat.div_done   = div_done && div_done_end;
        o_stat.blk_oob    = (q_start >= nb_wide);
        o_stat.chunk_last = (cnt_after == '0) || (blk_inc >= nb_wide);
        o_stat.entry_used = entry_used;
        o_stat.q_cont     = (r_blk <= q_end) && (r_blk < nb_wide);
    end

    // result register
    t_result r_result, n_result;
    logic    r_strobe;
    logic [1:0] load_st;

    always_comb begin
        if (r_req.map_value == r_free_marker) begin
            load_st = ST_FREE;
        end else if (r_req.map_value < r_file_sectors) begin
            load_st = ST_OK;
        end else begin
            load_st = ST_BEYOND;
        end

        n_result = '{status: ST_OK, file_sector: '0, chunk_sectors: '0,
                     overall_status: OV_ALLOC, last: 1'b1};
        case (i_cmd.emit)
            EM_LOAD: begin
                if (!idx_ok) begin
                    n_result.status         = ST_RANGE;
                    n_result.overall_status = OV_FAIL;
                end else begin
                    n_result.status         = load_st;
                    n_result.file_sector    = FS_W'(r_req.map_value);
                    n_result.overall_status = (load_st == ST_BEYOND) ? OV_FAIL : OV_ALLOC;
                end
            end
            EM_FAIL: begin
                n_result.status         = ST_RANGE;
                n_result.overall_status = OV_FAIL;
            end
            EM_CHUNK: begin
                n_result.status         = entry_used ? ST_OK : ST_FREE;
                n_result.file_sector    = entry_used ? FS_W'(map_rdata) + FS_W'(r_off) : '0;
                n_result.chunk_sectors  = take;
                n_result.overall_status = r_any ? OV_ALLOC : OV_NONE;
                n_result.last           = o_stat.chunk_last;
            end
            EM_QUERY: begin
                n_result.status         = r_any ? ST_OK : ST_FREE;
                n_result.overall_status = r_any ? OV_ALLOC : OV_NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.emit != EM_NONE);
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // the block walk never outruns the map: every chunk that a read emits lies inside the map
    a_step_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && i_cmd.emit == EM_CHUNK) |-> (r_blk < nb_wide))
        else $error("chunk emitted beyond map end");

endmodule

FILE: rtl/disk_image_block_map_translator.sv
// top level of the disk image block map translator: controller plus datapath
// depends on dbmt_pkg, dbmt_ctrl, dbmt_dp (and through it dbmt_div, dbmt_ram)
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start / busy           | i_req  (t_req)
//  result    | o_strobe, one cycle    | o_result (t_result)
//  config    | i_cfg_we, no wait      | i_cfg_addr, i_cfg_wdata
//
// a request is taken when start is high and busy is low; results follow as
// one-cycle strobes that the receiver cannot hold off
// load, unknown function and empty read: the result is emitted in the dispatch state
// and registered; read and query: a bit-serial divide (48 steps) and checks, then map
// entry reads on the single ram read port; a read makes a scan pass up to the first
// allocated or last chunk, then an emit pass, one ram read per chunk; a query only scans
// synchronous active-low reset; the block map is not cleared and must be loaded
`timescale 1ns / 1ps

module disk_image_block_map_translator #(
    parameter int MAP_DEPTH = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  dbmt_pkg::t_req               i_req,
    output logic                         o_strobe,
    output dbmt_pkg::t_result            o_result,
    input  logic                         i_cfg_we,
    input  logic [dbmt_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [dbmt_pkg::WORD_W-1:0]  i_cfg_wdata
);
    import dbmt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dbmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    dbmt_dp #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // the final result of a request shows exactly when the block has gone idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy == !o_result.last))
        else $error("last flag out of step with busy");

    // going idle always comes with a result
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("request finished without a result");

    // a freshly taken request produces nothing in the following cycle
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result right after accepting a request");

    // chunk results of one read are spaced by the ram read
    a_chunk_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> !o_strobe)
        else $error("back-to-back chunk results");

endmodule
